[sv/scr_pkg.sv]
`default_nettype none
package scr_pkg;
  localparam int Capacity = 32;
  localparam int SlotBits = 5;
  localparam int IdBits = 16;
  localparam int CountBits = 6;

  localparam logic [3:0] ReqPut = 4'd0;
  localparam logic [3:0] ReqAdd = 4'd1;
  localparam logic [3:0] ReqRemove = 4'd2;
  localparam logic [3:0] ReqGet = 4'd3;
  localparam logic [3:0] ReqNegate = 4'd4;
  localparam logic [3:0] ReqDivide = 4'd5;
  localparam logic [3:0] ReqClear = 4'd6;
  localparam logic [3:0] ReqReadPos = 4'd7;
  localparam logic [3:0] ReqAnyPos = 4'd8;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StDivZero = 2'd3;

  localparam logic [15:0] EpsilonReset = 16'd66;

  typedef struct packed {
    logic [3:0] req_type;
    logic [15:0] var_id;
    logic signed [31:0] operand_value;
    logic [4:0] position;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic signed [31:0] result_value;
    logic [15:0] result_id;
    logic any_positive;
    logic [5:0] entry_count;
  } rsp_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic signed [31:0] dividend;
    logic signed [31:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic done;
    logic signed [31:0] quotient;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

[sv/scr_if.sv]
`default_nettype none
interface scr_req_if (input wire logic clk);
  logic valid;
  logic ready;
  scr_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface scr_rsp_if (input wire logic clk);
  logic valid;
  logic ready;
  scr_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface scr_cfg_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/scr_div.sv]
`default_nettype none
// signed restoring divider: (dividend * 2^16) / divisor, truncated, saturated
// one quotient bit per cycle
module scr_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire scr_pkg::div_cmd_t cmd,
  output scr_pkg::div_rsp_t rsp
);
  logic busy;
  logic done;
  logic [5:0] cnt;
  logic [47:0] num;
  logic [32:0] rem;
  logic [31:0] den;
  logic neg;
  logic [33:0] trial;
  logic [47:0] qmag;
  logic signed [33:0] qs;
  logic signed [31:0] quotient;

  assign trial = {rem, num[47]} - {2'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (cmd.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt <= 6'd0;
        num <= {(cmd.dividend[31] ? 32'(-cmd.dividend) : 32'(cmd.dividend)), 16'd0};
        den <= cmd.divisor[31] ? 32'(-cmd.divisor) : 32'(cmd.divisor);
        neg <= cmd.dividend[31] ^ cmd.divisor[31];
        rem <= '0;
      end else if (busy) begin
        // one quotient bit per step, shifted into num
        if (!trial[33]) rem <= trial[32:0];
        else rem <= {rem[31:0], num[47]};
        num <= {num[46:0], ~trial[33]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  // sign and saturation on the finished magnitude
  always_comb begin
    qmag = num;
    if (qmag[47:33] != '0) qs = neg ? -34'sh0_8000_0000 : 34'sh0_7FFF_FFFF;
    else qs = neg ? -$signed({1'b0, qmag[32:0]}) : $signed({1'b0, qmag[32:0]});
    quotient = scr_pkg::sat32(qs);
  end

  assign rsp = {done, quotient};
endmodule
`default_nettype wire

[sv/scr_core.sv]
`default_nettype none
// list walker: visits one linked entry per cycle, except that a divide waits on the divider at each entry
module scr_core (
  input  wire logic clk,
  input  wire logic rst,
  scr_req_if.sink req,
  scr_rsp_if.source rsp,
  scr_cfg_if.sink cfg
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WALK  = 7'b0000010,
    S_DIVW  = 7'b0000100,
    S_APPLY = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_POS   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  scr_pkg::req_t r;
  logic [15:0] epsilon;

  logic [15:0] ids [scr_pkg::Capacity];
  logic signed [31:0] coeffs [scr_pkg::Capacity];
  logic [4:0] links [scr_pkg::Capacity];
  logic [scr_pkg::Capacity-1:0] valid_bits;
  logic head_none;
  logic [4:0] head;
  logic [5:0] count;

  logic cur_none;
  logic [4:0] cur;
  logic prev_none;
  logic [4:0] prev;
  logic [5:0] n;
  logic found;
  logic [4:0] found_slot;

  logic [1:0] status;
  logic signed [31:0] rval;
  logic [15:0] rid;
  logic anypos;

  scr_pkg::div_cmd_t dcmd;
  scr_pkg::div_rsp_t drsp;

  scr_div u_div (.clk(clk), .rst(rst), .cmd(dcmd), .rsp(drsp));

  // lowest free slot
  logic [4:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = scr_pkg::Capacity - 1; i >= 0; i--)
      if (!valid_bits[i]) free_slot = 5'(i);
  end

  logic walk_live;
  assign walk_live = !cur_none && (n < count);

  logic scan_busy;
  assign scan_busy = walk_live && !anypos;

  logic signed [31:0] cc;
  logic signed [33:0] sum;
  logic [31:0] eps32;
  logic val_small, sum_small;
  assign cc = coeffs[cur];
  assign sum = 34'(cc) + 34'(r.operand_value);
  assign eps32 = {16'd0, epsilon};
  assign val_small = (34'(r.operand_value) > -$signed({2'b0, eps32}))
                  && (34'(r.operand_value) < $signed({2'b0, eps32}));
  assign sum_small = (sum > -$signed({2'b0, eps32})) && (sum < $signed({2'b0, eps32}));

  // divider start as the walk reaches each entry
  always_comb begin
    dcmd.start = (state == S_WALK) && (r.req_type == scr_pkg::ReqDivide) && walk_live;
    dcmd.dividend = cc;
    dcmd.divisor = r.operand_value;
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = (state == S_OUT) && !scan_busy;
  assign rsp.payload.status = status;
  assign rsp.payload.result_value = rval;
  assign rsp.payload.result_id = rid;
  assign rsp.payload.any_positive = anypos;
  assign rsp.payload.entry_count = count;

  always_ff @(posedge clk) begin
    if (rst) epsilon <= scr_pkg::EpsilonReset;
    else if (cfg.valid) epsilon <= cfg.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid_bits <= '0;
      head_none <= 1'b1;
      head <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            r <= req.payload;
            status <= scr_pkg::StOk;
            rval <= '0;
            rid <= '0;
            cur_none <= head_none;
            cur <= head;
            prev_none <= 1'b1;
            n <= '0;
            found <= 1'b0;
            unique case (req.payload.req_type)
              scr_pkg::ReqPut, scr_pkg::ReqAdd, scr_pkg::ReqRemove, scr_pkg::ReqGet,
              scr_pkg::ReqNegate:
                state <= S_WALK;
              scr_pkg::ReqDivide: begin
                if (req.payload.operand_value == 0) begin
                  status <= scr_pkg::StDivZero;
                  state <= S_SCAN;
                end else state <= S_WALK;
              end
              scr_pkg::ReqClear: begin
                valid_bits <= '0;
                head_none <= 1'b1;
                count <= '0;
                state <= S_SCAN;
              end
              scr_pkg::ReqReadPos: begin
                status <= scr_pkg::StNotFound;
                state <= S_POS;
              end
              default: state <= S_SCAN;
            endcase
          end
        end
        S_WALK: begin
          if (r.req_type == scr_pkg::ReqNegate || r.req_type == scr_pkg::ReqDivide) begin
            // one entry each step
            if (!walk_live) state <= S_SCAN;
            else if (r.req_type == scr_pkg::ReqNegate) begin
              coeffs[cur] <= scr_pkg::sat32(-34'(cc));
              cur_none <= 1'b0;
              cur <= links[cur];
              n <= n + 6'd1;
            end else begin
              state <= S_DIVW;
            end
          end else if (walk_live && ids[cur] < r.var_id) begin
            prev_none <= 1'b0;
            prev <= cur;
            cur <= links[cur];
            n <= n + 6'd1;
          end else begin
            found <= walk_live && ids[cur] == r.var_id;
            found_slot <= cur;
            state <= S_APPLY;
          end
        end
        S_DIVW: begin
          if (drsp.done) begin
            coeffs[cur] <= drsp.quotient;
            cur <= links[cur];
            n <= n + 6'd1;
            state <= S_WALK;
          end
        end
        S_APPLY: begin
          state <= S_SCAN;
          if ((r.req_type == scr_pkg::ReqPut && r.operand_value == 0)
              || (r.req_type == scr_pkg::ReqAdd && found && !val_small && sum_small)
              || (r.req_type == scr_pkg::ReqRemove && found)) begin
            if (found) begin
              if (prev_none) head <= links[found_slot];
              else links[prev] <= links[found_slot];
              if (prev_none && count == 6'd1) head_none <= 1'b1;
              valid_bits[found_slot] <= 1'b0;
              count <= count - 6'd1;
              if (r.req_type == scr_pkg::ReqRemove) rval <= coeffs[found_slot];
            end
          end else if (r.req_type == scr_pkg::ReqRemove || r.req_type == scr_pkg::ReqGet) begin
            if (found) rval <= coeffs[found_slot];
            else status <= scr_pkg::StNotFound;
          end else if (r.req_type == scr_pkg::ReqAdd && val_small) begin
            if (found) rval <= coeffs[found_slot];
          end else if (found) begin
            if (r.req_type == scr_pkg::ReqPut) begin
              coeffs[found_slot] <= r.operand_value;
              rval <= r.operand_value;
            end else begin
              coeffs[found_slot] <= scr_pkg::sat32(sum);
              rval <= scr_pkg::sat32(sum);
            end
          end else if (count >= 6'(scr_pkg::Capacity)) begin
            status <= scr_pkg::StFull;
          end else begin
            ids[free_slot] <= r.var_id;
            coeffs[free_slot] <= r.operand_value;
            valid_bits[free_slot] <= 1'b1;
            if (prev_none) begin
              links[free_slot] <= head;
              head <= free_slot;
              head_none <= 1'b0;
            end else begin
              links[free_slot] <= links[prev];
              links[prev] <= free_slot;
            end
            count <= count + 6'd1;
            rval <= r.operand_value;
          end
        end
        S_POS: begin
          if (!walk_live) state <= S_SCAN;
          else if (n == {1'b0, r.position}) begin
            status <= scr_pkg::StOk;
            rval <= cc;
            rid <= ids[cur];
            state <= S_SCAN;
          end else begin
            cur <= links[cur];
            n <= n + 6'd1;
          end
        end
        S_SCAN: begin
          // restart walk for the positive test
          state <= S_OUT;
          anypos <= 1'b0;
          cur_none <= head_none;
          cur <= head;
          n <= '0;
        end
        S_OUT: begin
          // positive test runs before the result is offered
          if (scan_busy) begin
            if (cc > 0) anypos <= 1'b1;
            cur <= links[cur];
            n <= n + 6'd1;
          end else if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[sv/sparse_coefficient_row.sv]
// list requests walk the linked entries in order, then test the entries for a
// positive coefficient before the result is offered
// divide all waits at each entry on the 48-step divider
// one request at a time; ready is low from acceptance until the result is taken
// synchronous active-high reset empties the row and sets epsilon to 66
`default_nettype none
module sparse_coefficient_row (
  input wire logic clk,
  input wire logic rst,
  scr_req_if.sink req,
  scr_rsp_if.source rsp,
  scr_cfg_if.sink cfg
);
  scr_core u_core (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));
endmodule
`default_nettype wire
